// ----- rtl/ced_pkg.sv -----
// Shared types, constants and month tables for the civil date to epoch day converter.
// No dependencies; every rtl file imports this package.
package ced_pkg;

  localparam int YEAR_W  = 23;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 6;
  localparam int COUNT_W = 32;

  localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 23'd5000000;

  // floor(x / 25) = (x * DIV25_MAGIC) >> DIV25_SHIFT, exact for x < 2**21
  localparam int DIV25_SHIFT = 27;
  localparam int MAGIC_W     = 23;
  localparam logic [MAGIC_W-1:0] DIV25_MAGIC = 23'd5368710;

  localparam int QA_W = 17;  // (year / 4) / 25 fits 17 bits
  localparam int QB_W = 15;  // (year / 16) / 25 fits 15 bits

  // days from 0000-01-01 to 1970-01-01
  localparam logic [34:0] EPOCH_OFFSET = 35'd719528;
  localparam logic signed [34:0] COUNT_LIMIT = 35'sd2147483647;
  localparam logic signed [COUNT_W-1:0] INVALID_COUNT = 32'sh8000_0000;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } req_word_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] day_count;
    logic                      invalid;
  } rsp_word_t;

  typedef struct packed {
    logic [21:0] ceil4;
    logic [17:0] ceil100;
    logic [15:0] ceil400;
    logic        leap;
  } leap_info_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 6'd30;
      4'd2:                                       r = 6'd28;
      default:                                    r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ced_leap.sv -----
// Leap-year flag and the rounded-up year quotients by 4, 100 and 400.
// Depends on ced_pkg; takes the registered reciprocal products from stage one.
module ced_leap (
  input  logic [ced_pkg::YEAR_W-1:0] year,
  input  logic [43:0]                prod_a,
  input  logic [41:0]                prod_b,
  output ced_pkg::leap_info_t        info
);
  import ced_pkg::*;

  logic [QA_W-1:0] qa;
  logic [QB_W-1:0] qb;
  logic [20:0]     qa25;
  logic [18:0]     qb25;
  logic [4:0]      ra;
  logic [4:0]      rb;
  logic            rem100;
  logic            rem400;

  assign qa = prod_a[DIV25_SHIFT +: QA_W];
  assign qb = prod_b[DIV25_SHIFT +: QB_W];

  // 25 * q as shift-add; the remainder stays below 25
  assign qa25 = {qa, 4'b0} + {1'b0, qa, 3'b0} + {4'b0, qa};
  assign qb25 = {qb, 4'b0} + {1'b0, qb, 3'b0} + {4'b0, qb};
  logic [20:0] diff_a;
  logic [18:0] diff_b;
  assign diff_a = year[22:2] - qa25;
  assign diff_b = year[22:4] - qb25;
  assign ra = diff_a[4:0];
  assign rb = diff_b[4:0];

  assign rem100 = (year[1:0] != 2'b0) || (ra != 5'd0);
  assign rem400 = (year[3:0] != 4'b0) || (rb != 5'd0);

  assign info.ceil4   = {1'b0, year[22:2]} + {21'b0, (year[1:0] != 2'b0)};
  assign info.ceil100 = {1'b0, qa} + {17'b0, rem100};
  assign info.ceil400 = {1'b0, qb} + {15'b0, rem400};
  assign info.leap    = ((year[1:0] == 2'b0) && rem100) || !rem400;

endmodule

// ----- rtl/civil_date_to_epoch_days.sv -----
// Top level of the Gregorian date to epoch day converter: ports, pipeline, checks.
// Depends on ced_pkg and ced_leap.
//
// Converts a proleptic Gregorian date (year, month, day) into the signed day
// count since 1970-01-01. A date whose year exceeds max_year, whose month is
// outside 1..12, whose day is zero or past the month end (February has 29 days
// in leap years, year 0 included), or whose count does not fit 32 bits comes
// back with invalid set and day_count 0x80000000. The block takes one word per
// cycle while req_stall is low and returns each result through its three
// register stages: reciprocal multiplies, then leap and month checks, then the
// final day sum. Stages advance independently, so a stall on the result side
// fills bubbles first and backs up to req_stall only when every stage is full.
// max_year is written through the cfg port, which is always ready; write it
// only while no word is in flight.
module civil_date_to_epoch_days #(
  parameter logic [ced_pkg::YEAR_W-1:0] MaxYearReset = ced_pkg::MAX_YEAR_RESET
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  ced_pkg::req_word_t         req_word,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ced_pkg::rsp_word_t         rsp_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ced_pkg::YEAR_W-1:0] cfg_data
);
  import ced_pkg::*;

  logic [YEAR_W-1:0] max_year;

  // stage enables: a stage loads when it is empty or its successor loads
  logic en1, en2, en3;

  // stage one: raw fields, reciprocal products, 365 * year
  logic               v1;
  logic [YEAR_W-1:0]  s1_year;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic [43:0]        s1_prod_a;
  logic [41:0]        s1_prod_b;
  logic [31:0]        s1_y365;
  logic               s1_ok;

  // stage two: terms of the day sum and the date check
  logic        v2;
  logic [31:0] s2_y365;
  leap_info_t  s2_info;
  logic [8:0]  s2_dbm;
  logic [DAY_W-1:0] s2_dm1;
  logic        s2_ok;

  leap_info_t       leap_info;
  logic [DAY_W-1:0] len;
  logic [8:0]       dbm_next;
  logic             ok2_next;

  logic signed [34:0] count;
  logic [34:0]        total;
  logic               ok3_next;

  logic v3;

  assign en3       = !v3 || !rsp_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_stall = !en1;
  assign cfg_ready = 1'b1;

  // hold the configured year limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_year <= MaxYearReset;
    end else if (cfg_valid && cfg_ready) begin
      max_year <= cfg_data;
    end
  end

  // stage one: multiply by the reciprocal of 25 and by 365
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year   <= req_word.year;
      s1_month  <= req_word.month;
      s1_day    <= req_word.day;
      s1_prod_a <= req_word.year[22:2] * DIV25_MAGIC;
      s1_prod_b <= req_word.year[22:4] * DIV25_MAGIC;
      s1_y365   <= {9'b0, req_word.year} * 32'd365;
      s1_ok     <= (req_word.year <= max_year) && (req_word.month != 4'd0)
                   && (req_word.month <= MONTH_DEC) && (req_word.day != 6'd0);
    end
  end

  // stage two: leap flag, rounded quotients, month-end check
  ced_leap u_leap (
    .year   (s1_year),
    .prod_a (s1_prod_a),
    .prod_b (s1_prod_b),
    .info   (leap_info)
  );

  always_comb begin
    len      = month_length(s1_month)
               + {5'b0, (s1_month == MONTH_FEB) && leap_info.leap};
    dbm_next = days_before_month(s1_month)
               + {8'b0, (s1_month > MONTH_FEB) && leap_info.leap};
    ok2_next = s1_ok && (s1_day <= len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_y365 <= s1_y365;
      s2_info <= leap_info;
      s2_dbm  <= dbm_next;
      s2_dm1  <= s1_day - 6'd1;
      s2_ok   <= ok2_next;
    end
  end

  // stage three: add up the days, shift to the epoch, drop counts past 32 bits
  always_comb begin
    total = {3'b0, s2_y365} + {13'b0, s2_info.ceil4} - {17'b0, s2_info.ceil100}
            + {19'b0, s2_info.ceil400} + {26'b0, s2_dbm} + {29'b0, s2_dm1};
    count    = $signed(total - EPOCH_OFFSET);
    ok3_next = s2_ok && (count <= COUNT_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rsp_word.invalid   <= !ok3_next;
      rsp_word.day_count <= ok3_next ? count[COUNT_W-1:0] : INVALID_COUNT;
    end
  end

  assign rsp_valid = v3;

  // an invalid result always carries the marker count
  a_invalid_marker: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.invalid |-> rsp_word.day_count == INVALID_COUNT)
    else $error("invalid result without marker count");

  // a blocked middle stage keeps its word
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(s2_y365) && $stable(s2_ok) && $stable(s2_dbm))
    else $error("stage two word lost while blocked");

  // back-pressure on the request side only when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> v1 && v2 && v3 && rsp_stall)
    else $error("request stalled with an empty stage");

endmodule
